[hdl/brace_template_tokenizer_assert.svh]
// Assertion macros for the template tokenizer checker.
`ifndef BRACE_TEMPLATE_TOKENIZER_ASSERT_SVH
`define BRACE_TEMPLATE_TOKENIZER_ASSERT_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define BTT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clock and reset names.
`define BTT_ASSERT_DEF(lbl, prop, msg) \
  `BTT_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

[hdl/btt_pkg.sv]
package btt_pkg;

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 11;
  localparam logic [3:0] NAME_SAT = 4'd12;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    TOK_LITERAL = 2'd0,
    TOK_FIELD   = 2'd1,
    TOK_DONE    = 2'd2,
    TOK_ERROR   = 2'd3
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_EMPTY_TEMPLATE = 3'd0,
    ERR_STRAY_CLOSE    = 3'd1,
    ERR_MISSING_CLOSE  = 3'd2,
    ERR_EMPTY_FIELD    = 3'd3,
    ERR_UNKNOWN_FIELD  = 3'd4
  } err_code_e;

  // Keyword text, right-justified: last character in the low byte.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "TITLE", "ARTIST", "ALBUM", "ALBUMARTIST", "GENRE",
    "DATE", "TRACKNUMBER", "DISCNUMBER", "FILENAME"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd6, 4'd5, 4'd11, 4'd5, 4'd4, 4'd11, 4'd10, 4'd8
  };

  typedef logic [KW_COUNT-1:0] kw_mask_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } item_t;

  typedef struct packed {
    kw_mask_t   keep;
    logic       hit;
    logic [3:0] field_id;
  } kw_res_t;

  function automatic logic [7:0] kw_char(int unsigned k, logic [3:0] idx);
    int unsigned sh;
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(idx));
    return KW_TEXT[k][sh +: 8];
  endfunction

  function automatic logic [7:0] fold_upper(logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
  endfunction

endpackage

[hdl/btt_in_if.sv]
interface btt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source (output valid, output char_code, output end_mark, input ready);
  modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface

[hdl/btt_out_if.sv]
interface btt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  literal_char;
  logic [3:0]  field_id;
  logic [2:0]  error_code;
  logic [15:0] error_position;

  modport source (output valid, output token_kind, output literal_char, output field_id,
                  output error_code, output error_position, input ready);
  modport sink   (input valid, input token_kind, input literal_char, input field_id,
                  input error_code, input error_position, output ready);
endinterface

[hdl/btt_kw_match.sv]
module btt_kw_match
  import btt_pkg::*;
(
  input  logic [3:0] name_len_i,
  input  logic [7:0] char_i,
  input  kw_mask_t   cand_i,
  output kw_res_t    res_o
);

  always_comb begin
    res_o = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      res_o.keep[k] = (name_len_i < KW_LEN[k]) && (kw_char(k, name_len_i) == char_i);
    end
    // lowest matching index wins
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand_i[k] && (KW_LEN[k] == name_len_i)) begin
        res_o.hit      = 1'b1;
        res_o.field_id = 4'(k);
      end
    end
  end

endmodule

[hdl/btt_core.sv]
module btt_core
  import btt_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  item_t        item_i,
  output logic         item_ready_o,
  btt_out_if.source    out_o
);

  logic                     inside_q, inside_d;
  logic                     err_q, err_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] obp_q, obp_d;
  logic [3:0]               nlen_q, nlen_d;
  kw_mask_t                 cand_q, cand_d;

  logic        ov_q;
  tok_kind_e   kind_q, kind_d;
  logic [7:0]  lit_q, lit_d;
  logic [3:0]  fid_q, fid_d;
  err_code_e   ecode_q, ecode_d;
  logic [15:0] epos_q, epos_d;

  logic        has_res;
  logic        out_free;
  logic        go;
  logic [7:0]  up_char;
  logic [15:0] pos16, obp16;
  kw_res_t     kw;

  generate
    if (POSITION_BITS >= 16) begin : g_pos_wide
      assign pos16 = pos_q[15:0];
      assign obp16 = obp_q[15:0];
    end else begin : g_pos_narrow
      assign pos16 = {{(16-POSITION_BITS){1'b0}}, pos_q};
      assign obp16 = {{(16-POSITION_BITS){1'b0}}, obp_q};
    end
  endgenerate

  assign up_char = fold_upper(item_i.char_code);

  btt_kw_match u_kw_match (
    .name_len_i (nlen_q),
    .char_i     (up_char),
    .cand_i     (cand_q),
    .res_o      (kw)
  );

  always_comb begin
    inside_d = inside_q;
    err_d    = err_q;
    pos_d    = pos_q;
    obp_d    = obp_q;
    nlen_d   = nlen_q;
    cand_d   = cand_q;
    has_res  = 1'b0;
    kind_d   = TOK_LITERAL;
    lit_d    = '0;
    fid_d    = '0;
    ecode_d  = ERR_EMPTY_TEMPLATE;
    epos_d   = '0;

    if (item_i.end_mark) begin
      if (!err_q) begin
        has_res = 1'b1;
        if (inside_q) begin
          kind_d  = TOK_ERROR;
          ecode_d = ERR_MISSING_CLOSE;
          epos_d  = obp16;
        end else if (pos_q == '0) begin
          kind_d  = TOK_ERROR;
          ecode_d = ERR_EMPTY_TEMPLATE;
        end else begin
          kind_d  = TOK_DONE;
        end
      end
      inside_d = 1'b0;
      err_d    = 1'b0;
      pos_d    = '0;
      obp_d    = '0;
      nlen_d   = '0;
      cand_d   = '1;
    end else if (!err_q) begin
      if (pos_q != '1) pos_d = pos_q + 1'b1;
      if (!inside_q) begin
        if (item_i.char_code == CH_CLOSE) begin
          has_res = 1'b1;
          kind_d  = TOK_ERROR;
          ecode_d = ERR_STRAY_CLOSE;
          epos_d  = pos16;
          err_d   = 1'b1;
        end else if (item_i.char_code == CH_OPEN) begin
          inside_d = 1'b1;
          obp_d    = pos_q;
          nlen_d   = '0;
          cand_d   = '1;
        end else begin
          has_res = 1'b1;
          kind_d  = TOK_LITERAL;
          lit_d   = item_i.char_code;
        end
      end else if (item_i.char_code == CH_CLOSE) begin
        inside_d = 1'b0;
        has_res  = 1'b1;
        if (nlen_q == '0) begin
          kind_d  = TOK_ERROR;
          ecode_d = ERR_EMPTY_FIELD;
          epos_d  = obp16;
          err_d   = 1'b1;
        end else if (kw.hit) begin
          kind_d = TOK_FIELD;
          fid_d  = kw.field_id;
        end else begin
          kind_d  = TOK_ERROR;
          ecode_d = ERR_UNKNOWN_FIELD;
          epos_d  = obp16;
          err_d   = 1'b1;
        end
      end else begin
        cand_d = cand_q & kw.keep;
        if (nlen_q < NAME_SAT) nlen_d = nlen_q + 4'd1;
      end
    end
  end

  assign out_free     = !ov_q || out_o.ready;
  assign go           = item_valid_i && (!has_res || out_free);
  assign item_ready_o = !has_res || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      err_q    <= 1'b0;
      pos_q    <= '0;
      obp_q    <= '0;
      nlen_q   <= '0;
      cand_q   <= '1;
      ov_q     <= 1'b0;
    end else begin
      if (go) begin
        inside_q <= inside_d;
        err_q    <= err_d;
        pos_q    <= pos_d;
        obp_q    <= obp_d;
        nlen_q   <= nlen_d;
        cand_q   <= cand_d;
      end
      if (out_free) ov_q <= go && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && has_res && out_free) begin
      kind_q  <= kind_d;
      lit_q   <= lit_d;
      fid_q   <= fid_d;
      ecode_q <= ecode_d;
      epos_q  <= epos_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.token_kind     = kind_q;
  assign out_o.literal_char   = lit_q;
  assign out_o.field_id       = fid_q;
  assign out_o.error_code     = ecode_q;
  assign out_o.error_position = epos_q;

endmodule

[hdl/brace_template_tokenizer.sv]
// Rename-template tokenizer. One character transaction per cycle enters an input
// register unless the core stalls it; from that register the tokenizer state and
// a nine-way keyword compare update and the token, if any, lands in the output
// register, so the block sustains one character per clock while tokens are taken.
// Field openings and name characters produce no token. The output register holds
// a token until taken; the input side keeps taking characters that produce no
// token while it waits. Positions count up to 2^POSITION_BITS-1 and are reported
// in 16 bits.
module brace_template_tokenizer
  import btt_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  btt_in_if.sink    in_i,
  btt_out_if.source out_o
);

  logic  s1_valid_q;
  item_t s1_item_q;
  logic  core_ready;

  assign in_i.ready = !s1_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q <= '{char_code: in_i.char_code, end_mark: in_i.end_mark};
    end
  end

  btt_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_item_q),
    .item_ready_o (core_ready),
    .out_o        (out_o)
  );

endmodule

[hdl/btt_checker.sv]
`include "brace_template_tokenizer_assert.svh"

module btt_checker
  import btt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  token_kind_i,
  input logic [7:0]  literal_char_i,
  input logic [3:0]  field_id_i,
  input logic [2:0]  error_code_i,
  input logic [15:0] error_position_i
);

  `BTT_ASSERT_DEF(a_out_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "valid dropped")
  `BTT_ASSERT_DEF(a_out_stable, out_valid_i && !out_ready_i |=> $stable(token_kind_i) && $stable(error_position_i) && $stable(literal_char_i), "payload changed")
  `BTT_ASSERT_DEF(a_literal_clean, out_valid_i && token_kind_i == TOK_LITERAL |-> field_id_i == 4'd0 && error_code_i == ERR_EMPTY_TEMPLATE && error_position_i == 16'd0, "literal token fields")
  `BTT_ASSERT_DEF(a_field_ok, out_valid_i && token_kind_i == TOK_FIELD |-> field_id_i <= 4'd8 && literal_char_i == 8'd0 && error_position_i == 16'd0, "field token fields")

endmodule

bind brace_template_tokenizer btt_checker u_btt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .token_kind_i     (out_o.token_kind),
  .literal_char_i   (out_o.literal_char),
  .field_id_i       (out_o.field_id),
  .error_code_i     (out_o.error_code),
  .error_position_i (out_o.error_position)
);

[tb/brace_template_tokenizer_tb.sv]
module brace_template_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btt_pkg::*;

  localparam int unsigned STIM_ITEMS  = 1800;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [7:0]  UPPER_A     = 8'h41;
  // error_code reads zero on anything that is not an error
  localparam err_code_e   ERR_NONE    = ERR_EMPTY_TEMPLATE;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  lit;
    logic [3:0]  fid;
    err_code_e   code;
    logic [15:0] at;
  } token_t;

  typedef struct {
    item_t it;
    bit    hold;
  } pending_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  btt_in_if  in_if ();
  btt_out_if out_if ();

  brace_template_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  string kw_names [KW_COUNT] = '{
    "TITLE", "ARTIST", "ALBUM", "ALBUMARTIST", "GENRE",
    "DATE", "TRACKNUMBER", "DISCNUMBER", "FILENAME"
  };

  pending_t     pending [$];
  token_t       expected_tokens [$];
  logic [7:0]   name_buf [$];
  bit           tally = 1'b1;
  int unsigned  stim_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           in_taken = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  burst_left = 0;
  logic [7:0]   stall_pat = 8'hFF;
  logic [6:0]   stall_age = '0;
  token_t       got_tok;
  token_t       want_tok;
  item_t        taken_item;

  // tokenizer shadow state
  bit           in_field;
  bit           err_seen;
  logic [15:0]  pos_cnt;
  logic [15:0]  brace_at;
  logic [3:0]   name_len;
  kw_mask_t     cands;

  function automatic void expect_token(tok_kind_e kind, logic [7:0] lit, logic [3:0] fid,
                                       err_code_e code, logic [15:0] at);
    token_t t;
    t.kind = kind;
    t.lit  = lit;
    t.fid  = fid;
    t.code = code;
    t.at   = at;
    expected_tokens.push_back(t);
  endfunction

  function automatic void clear_tokenizer();
    in_field = 1'b0;
    err_seen = 1'b0;
    pos_cnt  = '0;
    brace_at = '0;
    name_len = '0;
    cands    = '1;
  endfunction

  function automatic void tokenize_step(item_t it);
    logic [15:0] at;
    logic [7:0]  up;
    kw_mask_t    keep;
    int          hit;
    int          k;
    at = pos_cnt;
    if (it.end_mark) begin
      if (!err_seen) begin
        if (in_field)
          expect_token(TOK_ERROR, 8'h00, 4'h0, ERR_MISSING_CLOSE, brace_at);
        else if (at == 16'h0)
          expect_token(TOK_ERROR, 8'h00, 4'h0, ERR_EMPTY_TEMPLATE, 16'h0);
        else
          expect_token(TOK_DONE, 8'h00, 4'h0, ERR_NONE, 16'h0);
      end
      clear_tokenizer();
      return;
    end
    if (err_seen) return;
    if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 16'd1;
    if (!in_field) begin
      if (it.char_code == CH_CLOSE) begin
        expect_token(TOK_ERROR, 8'h00, 4'h0, ERR_STRAY_CLOSE, at);
        err_seen = 1'b1;
      end else if (it.char_code == CH_OPEN) begin
        in_field = 1'b1;
        brace_at = at;
        name_len = '0;
        cands    = '1;
      end else begin
        expect_token(TOK_LITERAL, it.char_code, 4'h0, ERR_NONE, 16'h0);
      end
      return;
    end
    if (it.char_code == CH_CLOSE) begin
      in_field = 1'b0;
      hit = -1;
      for (k = KW_COUNT - 1; k >= 0; k--)
        if (cands[k] && kw_names[k].len() == int'(name_len)) hit = k;
      if (name_len == 4'd0) begin
        expect_token(TOK_ERROR, 8'h00, 4'h0, ERR_EMPTY_FIELD, brace_at);
        err_seen = 1'b1;
      end else if (hit >= 0) begin
        expect_token(TOK_FIELD, 8'h00, 4'(hit), ERR_NONE, 16'h0);
      end else begin
        expect_token(TOK_ERROR, 8'h00, 4'h0, ERR_UNKNOWN_FIELD, brace_at);
        err_seen = 1'b1;
      end
      return;
    end
    up = (it.char_code >= CH_LOW_A && it.char_code <= CH_LOW_Z) ?
         it.char_code - CASE_OFS : it.char_code;
    keep = '0;
    for (k = 0; k < KW_COUNT; k++)
      if (int'(name_len) < kw_names[k].len() && kw_names[k][name_len] == up) keep[k] = 1'b1;
    cands = cands & keep;
    if (name_len < NAME_SAT) name_len = name_len + 4'd1;
  endfunction

  function automatic void push_char(logic [7:0] c);
    pending_t p;
    p.it.char_code = c;
    p.it.end_mark  = 1'b0;
    p.hold         = 1'b0;
    pending.push_back(p);
    if (tally) stim_count++;
  endfunction

  function automatic void push_end();
    pending_t p;
    p.it.char_code = 8'($urandom_range(0, 255));
    p.it.end_mark  = 1'b1;
    p.hold         = 1'b0;
    pending.push_back(p);
    stim_count++;
  endfunction

  function automatic void push_hold();
    pending_t p;
    p.it   = '0;
    p.hold = 1'b1;
    pending.push_back(p);
  endfunction

  function automatic logic [7:0] rand_literal();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return UPPER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic void load_keyword(int k);
    int i;
    name_buf = {};
    for (i = 0; i < kw_names[k].len(); i++) name_buf.push_back(kw_names[k][i]);
  endfunction

  // name characters with letters in random case
  function automatic void push_name();
    logic [7:0] c;
    int i;
    for (i = 0; i < name_buf.size(); i++) begin
      c = name_buf[i];
      if (c >= UPPER_A && c < UPPER_A + 8'd26 && $urandom_range(0, 1) == 1) c = c + CASE_OFS;
      push_char(c);
    end
  endfunction

  function automatic void push_ignored();
    tally = 1'b0;
    repeat ($urandom_range(0, 4)) push_char(8'($urandom_range(0, 255)));
    tally = 1'b1;
  endfunction

  function automatic void note_mismatch(string what, token_t want, token_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected kind=%0d lit=%02h field=%0d err=%0d pos=%0d, got kind=%0d lit=%02h field=%0d err=%0d pos=%0d",
               $realtime, what, want.kind, want.lit, want.fid, want.code, want.at,
               got.kind, got.lit, got.fid, got.code, got.at);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sender: bursts with random gaps, holds on drain markers
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pending[0].hold) begin
        in_if.valid <= 1'b0;
        if (expected_tokens.size() == 0) pending.delete(0);
      end else begin
        in_if.valid     <= 1'b1;
        in_if.char_code <= pending[0].it.char_code;
        in_if.end_mark  <= pending[0].it.end_mark;
        pending.delete(0);
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: ready follows an 8-bit pattern, renewed whenever the 7-bit age counter wraps
  always @(negedge clk_i) begin
    if (stall_age == 7'd0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 8'hFF;
        1: stall_pat = 8'($urandom_range(0, 255)) | (8'h01 << $urandom_range(0, 7));
        2: stall_pat = 8'h01 << $urandom_range(0, 7);
        default: stall_pat = ~(8'h01 << $urandom_range(0, 7));
      endcase
    end
    stall_age = stall_age + 7'd1;
    out_if.ready <= stall_pat[stall_age[2:0]];
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("brace_template_tokenizer_tb failed");
      $finish;
    end else if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got_tok.kind = tok_kind_e'(out_if.token_kind);
        got_tok.lit  = out_if.literal_char;
        got_tok.fid  = out_if.field_id;
        got_tok.code = err_code_e'(out_if.error_code);
        got_tok.at   = out_if.error_position;
        if (expected_tokens.size() == 0) begin
          note_mismatch("unexpected token", '0, got_tok);
        end else begin
          want_tok = expected_tokens.pop_front();
          if (got_tok.kind !== want_tok.kind || got_tok.lit !== want_tok.lit ||
              got_tok.fid !== want_tok.fid || got_tok.code !== want_tok.code ||
              got_tok.at !== want_tok.at)
            note_mismatch("token mismatch", want_tok, got_tok);
        end
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        taken_item.char_code = in_if.char_code;
        taken_item.end_mark  = in_if.end_mark;
        tokenize_step(taken_item);
      end
    end
  end

  initial begin : stimulus
    int segs;
    int kind;
    int idx;
    in_if.valid     = 1'b0;
    in_if.char_code = 8'h00;
    in_if.end_mark  = 1'b0;
    out_if.ready    = 1'b0;
    clear_tokenizer();

    // directed: empty template, stray close, empty field, missing close,
    // brace inside a field, byte extremes, non-ASCII name byte
    push_end();
    push_char(CH_CLOSE); push_end();
    push_char(CH_OPEN); push_char(CH_CLOSE); push_end();
    push_char(8'h78); push_char(CH_OPEN); push_end();
    push_char(CH_OPEN); push_char(CH_OPEN); push_char(CH_CLOSE); push_end();
    push_char(8'hFF); push_char(8'h00); push_char(CH_OPEN); push_char(8'hC4);
    push_char(CH_CLOSE); push_end();
    push_hold();

    while (stim_count < STIM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) push_hold();
      if ($urandom_range(0, 9) < 7) begin
        segs = $urandom_range(1, 6);
        repeat (segs) begin
          if ($urandom_range(0, 2) == 0) begin
            load_keyword($urandom_range(0, KW_COUNT - 1));
            push_char(CH_OPEN);
            push_name();
            push_char(CH_CLOSE);
          end else begin
            repeat ($urandom_range(1, 5)) push_char(rand_literal());
          end
        end
        push_end();
      end else begin
        kind = $urandom_range(0, 5);
        if (kind != 0) repeat ($urandom_range(0, 3)) push_char(rand_literal());
        case (kind)
          0: ;
          1: begin
            push_char(CH_CLOSE);
            push_ignored();
          end
          2: begin
            push_char(CH_OPEN);
            if ($urandom_range(0, 1) == 0) begin
              load_keyword($urandom_range(0, KW_COUNT - 1));
              push_name();
            end else begin
              repeat ($urandom_range(0, 5)) push_char(rand_letter());
            end
          end
          3: begin
            push_char(CH_OPEN);
            push_char(CH_CLOSE);
            push_ignored();
          end
          4: begin
            load_keyword($urandom_range(0, KW_COUNT - 1));
            idx = $urandom_range(0, name_buf.size() - 1);
            case ($urandom_range(0, 5))
              0: if (name_buf.size() > 1) void'(name_buf.pop_back());
              1: name_buf.push_back(rand_letter());
              2: name_buf[idx] = UPPER_A +
                   8'((int'(name_buf[idx] - UPPER_A) + $urandom_range(1, 25)) % 26);
              3: begin
                name_buf = {};
                repeat ($urandom_range(12, 15)) name_buf.push_back(rand_letter());
              end
              4: name_buf.push_front(CH_OPEN);
              default: name_buf[idx] = 8'($urandom_range(128, 255));
            endcase
            push_char(CH_OPEN);
            push_name();
            push_char(CH_CLOSE);
            push_ignored();
          end
          default: begin
            repeat ($urandom_range(1, 12)) begin
              case ($urandom_range(0, 3))
                0: push_char(CH_OPEN);
                1: push_char(CH_CLOSE);
                2: push_char(rand_letter());
                default: push_char(8'($urandom_range(0, 255)));
              endcase
            end
          end
        endcase
        push_end();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_if.valid || expected_tokens.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_tokens.size() == 0)
      $display("brace_template_tokenizer_tb passed");
    else
      $display("brace_template_tokenizer_tb failed");
    $finish;
  end

endmodule
